// ===== hw/rtl/compacting_key_value_table_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CKVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ckvt_pkg.sv =====
package ckvt_pkg;

    localparam int KEY_W        = 32;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 7;
    localparam int IN_TDATA_W   = 96;
    localparam int OUT_TDATA_W  = 80;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP          = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GET_MISS     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEL_MISS     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UPD_MISS     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_UPD_CONFLICT = 3'd6;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [VALUE_W-1:0]      value;
    } t_entry;

endpackage

// ===== hw/rtl/ckvt_store.sv =====
module ckvt_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output ckvt_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  ckvt_pkg::t_entry  i_wr_data
);

    ckvt_pkg::t_entry mem [DEPTH];
    ckvt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/compacting_key_value_table.sv =====
// Channel      Dir  Signals                                   Contents
// command      in   s_axis_tvalid/tready/tdata/tuser          one add/delete/update/get
// result       out  m_axis_tvalid/tready/tdata                status, found entry, count
// limit        in   i_cfg_wr_en/i_cfg_wr_data                 capacity_limit register
//
// One command at a time: a command scans the held slots through the one read port, makes
// the last compare, decides and loads the result; an empty table skips the scan. Deleting
// slot i below the last adds a shift-down pass that moves each later slot down by one.
// Reset (i_rst_n low, synchronous) empties the table and sets the limit to 64; no
// clearing pass is run. s_axis_tready is high only while idle; a stalled result holds
// in the output register and holds the next command in its result-load step.
module compacting_key_value_table #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] key, [63:32] entry_key, [95:64] entry_value
    input  logic [ckvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [ckvt_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] status, [34:3] found_key, [66:35] found_value, [73:67] used_count,
    // [79:74] zero
    output logic [ckvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [ckvt_pkg::COUNT_W-1:0]        i_cfg_wr_data
);

    // Slot index and entry count widths follow the build capacity.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing the count against the 7-bit limit.
    localparam int LW    = (CNT_W > ckvt_pkg::COUNT_W) ? CNT_W : ckvt_pkg::COUNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_SHEND  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    // Control state
    logic [2:0]                     r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic [ckvt_pkg::COUNT_W-1:0]   r_limit;
    logic [IDX_W-1:0]               r_ptr, n_ptr;
    logic                           r_rd_vld;
    logic                           r_rd_shift;
    logic                           r_hit;
    logic                           r_nk_hit;
    logic                           r_o_valid;

    // Payload
    logic [ckvt_pkg::CMD_W-1:0]     r_cmd;
    logic signed [31:0]             r_key;
    logic signed [31:0]             r_nkey;
    logic [31:0]                    r_nval;
    logic [IDX_W-1:0]               r_rd_addr;
    logic [IDX_W-1:0]               r_hit_idx;
    ckvt_pkg::t_entry               r_found;
    logic [ckvt_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [ckvt_pkg::STATUS_W-1:0]  r_o_status;
    logic signed [31:0]             r_o_fkey;
    logic [31:0]                    r_o_fval;
    logic [ckvt_pkg::COUNT_W-1:0]   r_o_count;

    // Memory port signals
    logic                           w_rd_en;
    logic [IDX_W-1:0]               w_rd_addr;
    ckvt_pkg::t_entry               w_rd_data;
    logic                           w_wr_en;
    logic [IDX_W-1:0]               w_wr_addr;
    ckvt_pkg::t_entry               w_wr_data;

    logic                           w_in_xfer;
    logic                           w_load_out;
    logic [CNT_W-1:0]               w_last;
    logic [LW-1:0]                  w_lim_ext;
    logic [LW-1:0]                  w_cap_ext;
    logic [LW-1:0]                  w_eff_lim;
    logic [LW-1:0]                  w_count_ext;
    logic                           w_full;
    logic                           w_k_match;
    logic                           w_nk_match;
    logic                           w_get_ok;

    ckvt_store #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Index of the last held slot; only meaningful while the table is not empty.
    assign w_last      = r_count - 1'b1;
    assign w_lim_ext   = LW'(r_limit);
    assign w_cap_ext   = LW'(CAPACITY);
    assign w_eff_lim   = (w_lim_ext < w_cap_ext) ? w_lim_ext : w_cap_ext;
    assign w_count_ext = LW'(r_count);
    assign w_full      = (w_count_ext >= w_eff_lim);

    // Compare the slot read in the previous cycle against both keys.
    assign w_k_match  = r_rd_vld && !r_rd_shift && (w_rd_data.key == r_key);
    assign w_nk_match = r_rd_vld && !r_rd_shift && (w_rd_data.key == r_nkey);

    always_comb begin
        n_state      = r_state;
        n_ptr        = r_ptr;
        n_count      = r_count;
        n_res_status = r_res_status;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_ptr;
        w_load_out   = 1'b0;
        // Shift pass: move the slot read last cycle down by one.
        w_wr_en      = r_rd_vld && r_rd_shift;
        w_wr_addr    = r_rd_addr - 1'b1;
        w_wr_data    = w_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_ptr   = '0;
                    n_state = (r_count == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN: begin
                w_rd_en = 1'b1;
                if (CNT_W'(r_ptr) == w_last) begin
                    n_state = S_LAST;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_LAST: begin
                // Last slot compares in this cycle.
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_res_status = ckvt_pkg::ST_OK;
                n_state      = S_OUT;
                case (r_cmd)
                    ckvt_pkg::CMD_ADD: begin
                        if (w_full) begin
                            n_res_status = ckvt_pkg::ST_FULL;
                        end else if (r_nk_hit) begin
                            n_res_status = ckvt_pkg::ST_DUP;
                        end else begin
                            w_wr_en         = 1'b1;
                            w_wr_addr       = r_count[IDX_W-1:0];
                            w_wr_data.key   = r_nkey;
                            w_wr_data.value = r_nval;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    ckvt_pkg::CMD_DELETE: begin
                        if (!r_hit) begin
                            n_res_status = ckvt_pkg::ST_DEL_MISS;
                        end else if (CNT_W'(r_hit_idx) != w_last) begin
                            n_ptr   = r_hit_idx + 1'b1;
                            n_state = S_SHIFT;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    ckvt_pkg::CMD_UPDATE: begin
                        if (!r_hit) begin
                            n_res_status = ckvt_pkg::ST_UPD_MISS;
                        end else if (r_nk_hit && (r_nkey != r_key)) begin
                            n_res_status = ckvt_pkg::ST_UPD_CONFLICT;
                        end else begin
                            w_wr_en         = 1'b1;
                            w_wr_addr       = r_hit_idx;
                            w_wr_data.key   = r_nkey;
                            w_wr_data.value = r_nval;
                        end
                    end
                    default: begin
                        if (!r_hit) begin
                            n_res_status = ckvt_pkg::ST_GET_MISS;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                w_rd_en = 1'b1;
                if (CNT_W'(r_ptr) == w_last) begin
                    n_state = S_SHEND;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SHEND: begin
                // Final move lands this cycle.
                n_count = r_count - 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_get_ok = (r_cmd == ckvt_pkg::CMD_GET) && (r_res_status == ckvt_pkg::ST_OK);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_limit    <= ckvt_pkg::LIMIT_RESET;
            r_ptr      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_shift <= 1'b0;
            r_hit      <= 1'b0;
            r_nk_hit   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ptr      <= n_ptr;
            r_rd_vld   <= w_rd_en;
            r_rd_shift <= (r_state == S_SHIFT);
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            // Clear match flags at each new command; latch the first key match.
            if (w_in_xfer) begin
                r_hit    <= 1'b0;
                r_nk_hit <= 1'b0;
            end else begin
                if (w_k_match) begin
                    r_hit <= 1'b1;
                end
                if (w_nk_match) begin
                    r_nk_hit <= 1'b1;
                end
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr    <= w_rd_addr;
        r_res_status <= n_res_status;
        if (w_in_xfer) begin
            r_cmd  <= s_axis_tuser;
            r_key  <= s_axis_tdata[31:0];
            r_nkey <= s_axis_tdata[63:32];
            r_nval <= s_axis_tdata[95:64];
        end
        if (w_k_match && !r_hit) begin
            r_hit_idx <= r_rd_addr;
            r_found   <= w_rd_data;
        end
        if (w_load_out) begin
            r_o_status <= r_res_status;
            r_o_fkey   <= w_get_ok ? r_found.key : '0;
            r_o_fval   <= w_get_ok ? r_found.value : '0;
            r_o_count  <= w_count_ext[ckvt_pkg::COUNT_W-1:0];
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'b0, r_o_count, r_o_fval, r_o_fkey, r_o_status};

endmodule

// ===== hw/rtl/ckvt_checker.sv =====
`include "compacting_key_value_table_defines.svh"

module ckvt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ckvt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [ckvt_pkg::STATUS_W-1:0] w_status;
    logic                          w_stall;
    logic                          w_fail;
    logic                          w_status_ok;
    logic [63:0]                   w_found;

    assign w_status    = m_axis_tdata[2:0];
    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_fail      = m_axis_tvalid && (w_status != ckvt_pkg::ST_OK);
    assign w_status_ok = (w_status <= ckvt_pkg::ST_UPD_CONFLICT);
    assign w_found     = m_axis_tdata[66:3];

    // A stalled result must stay put.
    `CKVT_ASSERT_NEXT(a_out_hold, w_stall, m_axis_tvalid && $stable(m_axis_tdata), "result moved")

    // Any failure carries zero in the found key and payload.
    `CKVT_ASSERT_NOW(a_fail_zero, w_fail, w_found == '0, "failure result with nonzero found fields")

    // Status stays within the defined codes.
    `CKVT_ASSERT_NOW(a_status_range, m_axis_tvalid, w_status_ok, "undefined status code")

endmodule

bind compacting_key_value_table ckvt_checker u_ckvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    // Package constants used throughout the bench.
    localparam int KEY_W       = ckvt_pkg::KEY_W;
    localparam int VALUE_W     = ckvt_pkg::VALUE_W;
    localparam int CMD_W       = ckvt_pkg::CMD_W;
    localparam int STATUS_W    = ckvt_pkg::STATUS_W;
    localparam int COUNT_W     = ckvt_pkg::COUNT_W;
    localparam int IN_TDATA_W  = ckvt_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = ckvt_pkg::OUT_TDATA_W;

    localparam logic [CMD_W-1:0] CMD_ADD    = ckvt_pkg::CMD_ADD;
    localparam logic [CMD_W-1:0] CMD_DELETE = ckvt_pkg::CMD_DELETE;
    localparam logic [CMD_W-1:0] CMD_UPDATE = ckvt_pkg::CMD_UPDATE;
    localparam logic [CMD_W-1:0] CMD_GET    = ckvt_pkg::CMD_GET;

    localparam logic [STATUS_W-1:0] ST_OK           = ckvt_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_FULL         = ckvt_pkg::ST_FULL;
    localparam logic [STATUS_W-1:0] ST_DUP          = ckvt_pkg::ST_DUP;
    localparam logic [STATUS_W-1:0] ST_GET_MISS     = ckvt_pkg::ST_GET_MISS;
    localparam logic [STATUS_W-1:0] ST_DEL_MISS     = ckvt_pkg::ST_DEL_MISS;
    localparam logic [STATUS_W-1:0] ST_UPD_MISS     = ckvt_pkg::ST_UPD_MISS;
    localparam logic [STATUS_W-1:0] ST_UPD_CONFLICT = ckvt_pkg::ST_UPD_CONFLICT;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = ckvt_pkg::LIMIT_RESET;

    localparam int TABLE_DEPTH   = 64;
    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 12;
    // Slowest legal command is a full scan plus a full shift;
    // ~1150 commands with stalls stay far below this.
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 200;
    localparam int HOLD_AT_REPLY = 200;
    localparam int HOLD_CYCLES   = 500;
    localparam int IDLE_PCT      = 15;
    localparam int MAX_REPORTS   = 10;
    localparam int POOL_MAX      = TABLE_DEPTH + 8;

    localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0]      VALUE_MAX = 32'hFFFF_FFFF;

    typedef enum logic {ROW_CMD, ROW_LIMIT} t_row_kind;

    // One result transfer, unpacked from m_axis_tdata.
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] found_key;
        logic [VALUE_W-1:0]      found_value;
        logic [COUNT_W-1:0]      used_count;
    } t_reply;

    // One line of the directed sequence: a command, or a limit write between commands.
    typedef struct {
        t_row_kind               kind;
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] entry_key;
        logic [VALUE_W-1:0]      entry_value;
        logic [COUNT_W-1:0]      limit;
        bit                      typed;
        t_reply                  reply;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // [31:0] key, [63:32] entry_key, [95:64] entry_value
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    // [1:0] cmd
    logic [CMD_W-1:0]           s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // [2:0] status, [34:3] found_key, [66:35] found_value, [73:67] used_count
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                       i_cfg_wr_en;
    logic [COUNT_W-1:0]         i_cfg_wr_data;

    // Shadow copy of the table: entries, fill level and the limit register.
    ckvt_pkg::t_entry           held_entries [TABLE_DEPTH];
    int unsigned                held_count;
    logic [COUNT_W-1:0]         limit_shadow;

    t_reply                     pending_replies [$];
    t_stim_row                  stim_rows [$];
    logic signed [KEY_W-1:0]    key_pool [POOL_MAX];
    int                         pool_size;
    bit                         quiet;
    int                         commands_sent;
    int                         replies_seen;
    int                         mismatches;
    int                         limits_written;
    int                         status_tally [8];
    int                         cycle_count = 0;

    compacting_key_value_table #(
        .CAPACITY (TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF_NS;
        i_clk = 1'b1;
        #CLK_HALF_NS;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return the first held slot carrying k, or held_count on a miss.
    function automatic int unsigned find_held(input logic signed [KEY_W-1:0] k);
        int unsigned i;
        for (i = 0; i < held_count; i++) begin
            if (held_entries[i].key == k) begin
                return i;
            end
        end
        return held_count;
    endfunction

    // Apply one command to the shadow table and return the result it must produce.
    function automatic t_reply kv_apply(input logic [CMD_W-1:0] cmd,
                                        input logic signed [KEY_W-1:0] k,
                                        input logic signed [KEY_W-1:0] nk,
                                        input logic [VALUE_W-1:0] nv);
        t_reply      r;
        int unsigned slot;
        int unsigned j;
        int unsigned room;
        bit          clash;
        r        = '0;
        r.status = ST_OK;
        // A limit above the build depth clamps to the depth.
        room     = (limit_shadow < TABLE_DEPTH) ? limit_shadow : TABLE_DEPTH;
        slot     = find_held((cmd == CMD_ADD) ? nk : k);
        case (cmd)
            CMD_ADD: begin
                // Full wins over duplicate, even when the key is already held.
                if (held_count >= room) begin
                    r.status = ST_FULL;
                end else if (slot < held_count) begin
                    r.status = ST_DUP;
                end else begin
                    held_entries[held_count].key   = nk;
                    held_entries[held_count].value = nv;
                    held_count++;
                end
            end
            CMD_DELETE: begin
                if (slot >= held_count) begin
                    r.status = ST_DEL_MISS;
                end else begin
                    // Close the gap: shift every later entry down one slot.
                    for (j = slot; j + 1 < held_count; j++) begin
                        held_entries[j] = held_entries[j + 1];
                    end
                    held_count--;
                end
            end
            CMD_UPDATE: begin
                if (slot >= held_count) begin
                    r.status = ST_UPD_MISS;
                end else begin
                    // Keeping the same key skips the conflict scan.
                    clash = 1'b0;
                    if (nk != k) begin
                        for (j = 0; j < held_count; j++) begin
                            if (j != slot && held_entries[j].key == nk) begin
                                clash = 1'b1;
                            end
                        end
                    end
                    if (clash) begin
                        r.status = ST_UPD_CONFLICT;
                    end else begin
                        held_entries[slot].key   = nk;
                        held_entries[slot].value = nv;
                    end
                end
            end
            default: begin
                if (slot >= held_count) begin
                    r.status = ST_GET_MISS;
                end else begin
                    r.found_key   = held_entries[slot].key;
                    r.found_value = held_entries[slot].value;
                end
            end
        endcase
        r.used_count = held_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Seed the key pool with the extremes, zero and minus one, then random keys.
    task automatic fill_pool(input int n);
        int i;
        pool_size = (n > POOL_MAX) ? POOL_MAX : n;
        for (i = 0; i < pool_size; i++) begin
            key_pool[i] = $urandom;
        end
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = '1;
    endtask

    // Key to search for: mostly a held key so that hits and shifts dominate.
    function automatic logic signed [KEY_W-1:0] pick_probe_key();
        int r;
        r = $urandom_range(0, 99);
        if (held_count > 0 && r < 50) begin
            return held_entries[$urandom_range(0, held_count - 1)].key;
        end
        if (r < 90) begin
            return key_pool[$urandom_range(0, pool_size - 1)];
        end
        return $urandom;
    endfunction

    // Key for a new entry: sometimes a held one to provoke duplicates and conflicts.
    function automatic logic signed [KEY_W-1:0] pick_new_key();
        int r;
        r = $urandom_range(0, 99);
        if (held_count > 0 && r < 15) begin
            return held_entries[$urandom_range(0, held_count - 1)].key;
        end
        if (r < 90) begin
            return key_pool[$urandom_range(0, pool_size - 1)];
        end
        return $urandom;
    endfunction

    // Offer one command and hold it until the transfer; queue its result.
    // Enter and leave at a falling edge; valid stays high for a back-to-back follower.
    task automatic offer_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [KEY_W-1:0] k,
                                 input logic signed [KEY_W-1:0] ek,
                                 input logic [VALUE_W-1:0] ev,
                                 input bit typed,
                                 input t_reply typed_reply);
        int     gap;
        t_reply want;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev, ek, k};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        // Advance the shadow table on every transfer; a typed row overrides the prediction.
        want = kv_apply(cmd, k, ek, ev);
        if (typed) begin
            want = typed_reply;
        end
        pending_replies.push_back(want);
        status_tally[want.status]++;
        commands_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write the limit register only with the block idle and nothing outstanding.
    task automatic write_limit(input logic [COUNT_W-1:0] v);
        drain_replies();
        while (!s_axis_tready) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        limit_shadow   = v;
        limits_written++;
        @(negedge i_clk);
    endtask

    task automatic row_cmd(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] k,
                           input logic signed [KEY_W-1:0] ek, input logic [VALUE_W-1:0] ev);
        t_stim_row row;
        row             = '{kind: ROW_CMD, default: '0};
        row.kind        = ROW_CMD;
        row.cmd         = cmd;
        row.key         = k;
        row.entry_key   = ek;
        row.entry_value = ev;
        stim_rows.push_back(row);
    endtask

    task automatic row_typed(input logic [CMD_W-1:0] cmd, input logic signed [KEY_W-1:0] k,
                             input logic signed [KEY_W-1:0] ek, input logic [VALUE_W-1:0] ev,
                             input logic [STATUS_W-1:0] st, input logic signed [KEY_W-1:0] fk,
                             input logic [VALUE_W-1:0] fv, input logic [COUNT_W-1:0] cnt);
        t_stim_row row;
        row                   = '{kind: ROW_CMD, default: '0};
        row.kind              = ROW_CMD;
        row.cmd               = cmd;
        row.key               = k;
        row.entry_key         = ek;
        row.entry_value       = ev;
        row.typed             = 1'b1;
        row.reply.status      = st;
        row.reply.found_key   = fk;
        row.reply.found_value = fv;
        row.reply.used_count  = cnt;
        stim_rows.push_back(row);
    endtask

    task automatic row_limit(input logic [COUNT_W-1:0] v);
        t_stim_row row;
        row       = '{kind: ROW_LIMIT, default: '0};
        row.kind  = ROW_LIMIT;
        row.limit = v;
        stim_rows.push_back(row);
    endtask

    // Directed sequence: empty-table misses, key and payload extremes, duplicate add,
    // update conflict and same-key update, delete with shift, a limit lowered below
    // the fill level, a limit above the build depth and a zero limit.
    task automatic build_directed_rows();
        row_typed(CMD_GET,    32'sd5, '0, '0, ST_GET_MISS, '0, '0, 7'd0);
        row_typed(CMD_DELETE, 32'sd5, '0, '0, ST_DEL_MISS, '0, '0, 7'd0);
        row_typed(CMD_UPDATE, 32'sd5, 32'sd6, '0, ST_UPD_MISS, '0, '0, 7'd0);
        row_typed(CMD_ADD,    '0, KEY_MIN, '0, ST_OK, '0, '0, 7'd1);
        row_typed(CMD_ADD,    '0, KEY_MAX, VALUE_MAX, ST_OK, '0, '0, 7'd2);
        row_typed(CMD_ADD,    '0, KEY_MIN, 32'd1, ST_DUP, '0, '0, 7'd2);
        row_typed(CMD_GET,    KEY_MAX, '0, '0, ST_OK, KEY_MAX, VALUE_MAX, 7'd2);
        row_typed(CMD_UPDATE, KEY_MIN, KEY_MAX, 32'd7, ST_UPD_CONFLICT, '0, '0, 7'd2);
        row_cmd(CMD_UPDATE,   KEY_MIN, KEY_MIN, 32'hA5A5_A5A5);
        row_cmd(CMD_GET,      KEY_MIN, '0, '0);
        row_cmd(CMD_ADD,      '0, '0, 32'h1234_5678);
        row_cmd(CMD_ADD,      '0, '1, 32'h5A5A_5A5A);
        row_cmd(CMD_UPDATE,   '0, 32'sh1357_2468, 32'hDEAD_0001);
        row_cmd(CMD_DELETE,   KEY_MIN, '0, '0);
        row_cmd(CMD_GET,      '1, '0, '0);
        row_typed(CMD_DELETE, 32'sd99, '0, '0, ST_DEL_MISS, '0, '0, 7'd3);
        // Lower the limit under the fill level: held entries stay reachable.
        row_limit(7'd2);
        row_cmd(CMD_GET,      '1, '0, '0);
        row_typed(CMD_ADD,    '0, '1, 32'd3, ST_FULL, '0, '0, 7'd3);
        row_cmd(CMD_DELETE,   KEY_MAX, '0, '0);
        row_typed(CMD_ADD,    '0, 32'sd7, 32'd4, ST_FULL, '0, '0, 7'd2);
        row_cmd(CMD_DELETE,   '1, '0, '0);
        row_cmd(CMD_ADD,      '0, 32'sd7, 32'h0BAD_F00D);
        row_limit(7'd127);
        row_limit(7'd0);
        row_typed(CMD_ADD,    '0, 32'sd1, 32'd5, ST_FULL, '0, '0, 7'd2);
        row_cmd(CMD_GET,      32'sd7, '0, '0);
        row_typed(CMD_UPDATE, 32'sd99, 32'sd100, '0, ST_UPD_MISS, '0, '0, 7'd2);
    endtask

    // One random stretch at a given limit; add_pct steers filling versus draining.
    task automatic run_phase(input logic [COUNT_W-1:0] lim, input int items,
                             input int add_pct, input bit calm);
        int                      n;
        int                      room;
        logic [CMD_W-1:0]        cmd;
        logic signed [KEY_W-1:0] k;
        logic signed [KEY_W-1:0] ek;
        logic [VALUE_W-1:0]      ev;
        write_limit(lim);
        quiet = calm;
        room  = (lim < TABLE_DEPTH) ? lim : TABLE_DEPTH;
        fill_pool(room + 8);
        for (n = 0; n < items; n++) begin
            if ($urandom_range(0, 99) < add_pct) begin
                cmd = CMD_ADD;
            end else begin
                case ($urandom_range(0, 2))
                    0: cmd = CMD_DELETE;
                    1: cmd = CMD_UPDATE;
                    default: cmd = CMD_GET;
                endcase
            end
            k  = pick_probe_key();
            // Same-key updates skip the conflict scan; keep plenty of them.
            if (cmd == CMD_UPDATE && $urandom_range(0, 99) < 40) begin
                ek = k;
            end else begin
                ek = pick_new_key();
            end
            ev = $urandom;
            offer_command(cmd, k, ek, ev, 1'b0, '0);
        end
        quiet = 1'b0;
    endtask

    task automatic report_reply(input string what, input t_reply want, input t_reply got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%s reply %0d: status %0d/%0d key %h/%h value %h/%h count %0d/%0d (want/got)",
                     what, replies_seen, want.status, got.status, want.found_key, got.found_key,
                     want.found_value, got.found_value, want.used_count, got.used_count);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check every transfer, idle at random, one long hold-off
    // ------------------------------------------------------------------
    initial begin : reply_sink
        t_reply got;
        t_reply want;
        int     hold_left;
        bit     hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.status      = m_axis_tdata[2:0];
                got.found_key   = m_axis_tdata[34:3];
                got.found_value = m_axis_tdata[66:35];
                got.used_count  = m_axis_tdata[73:67];
                if (pending_replies.size() == 0) begin
                    report_reply("unexpected", '0, got);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.found_key !== want.found_key ||
                        got.found_value !== want.found_value ||
                        got.used_count !== want.used_count) begin
                        report_reply("mismatch", want, got);
                    end
                end
                replies_seen++;
            end
            @(negedge i_clk);
            // Hold off once for a long stretch so the block backs up and drops s_axis_tready.
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && replies_seen >= HOLD_AT_REPLY) begin
                hold_done      = 1'b1;
                hold_left      = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side: reset, directed rows, random phases, final drain
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row row;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = CMD_ADD;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = LIMIT_RESET;
        held_count      = 0;
        limit_shadow    = LIMIT_RESET;
        quiet           = 1'b0;
        commands_sent   = 0;
        replies_seen    = 0;
        mismatches      = 0;
        limits_written  = 0;
        status_tally    = '{default: 0};
        build_directed_rows();
        fill_pool(8);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_LIMIT) begin
                write_limit(row.limit);
            end else begin
                offer_command(row.cmd, row.key, row.entry_key, row.entry_value,
                              row.typed, row.reply);
            end
        end

        // Fill to the build depth, then a single slot, then above the depth with no idling on
        // either side, a mid limit, a zero limit that drains, a random one, the depth again.
        run_phase(7'd64,  300, 45, 1'b0);
        run_phase(7'd1,   100, 35, 1'b0);
        run_phase(7'd127, 250, 40, 1'b1);
        run_phase(7'd20,  150, 35, 1'b0);
        run_phase(7'd0,    75, 20, 1'b0);
        run_phase(7'($urandom_range(2, 63)), 150, 35, 1'b0);
        run_phase(7'd64,  100, 50, 1'b0);

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands over %0d limit writes: ok %0d full %0d dup %0d",
                 commands_sent, limits_written, status_tally[ST_OK], status_tally[ST_FULL],
                 status_tally[ST_DUP]);
        $display("getmiss %0d delmiss %0d updmiss %0d conflict %0d, %0d checked, %0d bad",
                 status_tally[ST_GET_MISS], status_tally[ST_DEL_MISS],
                 status_tally[ST_UPD_MISS], status_tally[ST_UPD_CONFLICT], replies_seen,
                 mismatches);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== compacting_key_value_table.f =====
+incdir+hw/rtl
hw/rtl/ckvt_pkg.sv
hw/rtl/ckvt_store.sv
hw/rtl/compacting_key_value_table.sv
hw/rtl/ckvt_checker.sv
tb/tb.sv
